// ----- hdl/prefix_code_bit_decoder_macros.svh -----
// Shared assertion macros for the prefix code bit decoder.
// Both expect clk and rst_n in scope.
`ifndef PREFIX_CODE_BIT_DECODER_MACROS_SVH
`define PREFIX_CODE_BIT_DECODER_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define PCBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define PCBD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/pcbd_pkg.sv -----
`default_nettype none

package pcbd_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int MAX_CODE_LEN  = 32;
    localparam int SYMBOL_BITS   = 16;

    // field widths
    localparam int ENTRY_IDX_W = 8;
    localparam int CODE_W      = 32;
    localparam int CODE_LEN_W  = 6;

    // code table split into banks, all banks read at the same row each cycle of a scan
    localparam int BANKS       = 8;
    localparam int BANK_SEL_W  = $clog2(BANKS);
    localparam int BANK_DEPTH  = TABLE_ENTRIES / BANKS;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_BIT  = 1'b1;

    typedef struct packed {
        logic                   req_type;
        logic [ENTRY_IDX_W-1:0] entry_index;
        logic [15:0]            entry_symbol;
        logic [CODE_W-1:0]      entry_code;
        logic [CODE_LEN_W-1:0]  entry_code_len;
        logic                   code_bit;
    } req_t;

    typedef struct packed {
        logic [15:0] symbol;
        logic        overflow_error;
    } rsp_t;

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic [CODE_W-1:0]      code;
        logic [CODE_LEN_W-1:0]  code_len;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic write;     // store a table entry
        logic shift;     // take a bit into the window, restart the scan
        logic overflow;  // window full: clear it, queue an error result
        logic scan;      // read the next row of all banks
        logic match;     // queue the hit symbol, clear the window
        logic push;      // move the queued result to the output register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic win_full;
        logic hit;
        logic last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/pcbd_ctrl.sv -----
`default_nettype none
`include "prefix_code_bit_decoder_macros.svh"

module pcbd_ctrl
    import pcbd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire logic     req_type,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PUSH} state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        cmd.write = 1'b1;
                    end
                    else if (stat.win_full)
                    begin
                        cmd.overflow = 1'b1;
                        state_next   = S_PUSH;
                    end
                    else
                    begin
                        cmd.shift  = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    cmd.match  = 1'b1;
                    state_next = S_PUSH;
                end
                else if (stat.last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PUSH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.push)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    `PCBD_ASSERT(a_push_free, (cmd.push |-> (!rsp_valid_reg || rsp_ready)), "result overwritten")
    `PCBD_ASSERT(a_hit_push, ((state_reg == S_SCAN && stat.hit) |=> state_reg == S_PUSH), "hit lost")
    `PCBD_ASSERT(a_rsp_src, ($rose(rsp_valid_reg) |-> $past(state_reg) == S_PUSH), "stray result")

endmodule

`default_nettype wire

// ----- hdl/pcbd_datapath.sv -----
`default_nettype none
`include "prefix_code_bit_decoder_macros.svh"

module pcbd_datapath
    import pcbd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire req_t     req,
    input  wire ctl_cmd_t cmd,
    output dp_stat_t      stat,
    output rsp_t          rsp
);

    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [CODE_W-1:0]        win_bits_reg;
    logic [CODE_LEN_W-1:0]    win_len_reg;
    logic [CODE_W-1:0]        mask_reg;
    logic [BANK_AW-1:0]       scan_addr_reg;
    logic                     rd_valid_reg;
    logic                     rd_last_reg;

    entry_t     rd_entry_reg [BANKS];
    logic [BANKS-1:0] rd_used_reg;
    rsp_t       res_reg;
    rsp_t       rsp_reg;

    logic [BANK_SEL_W-1:0] wr_bank;
    logic [BANK_AW-1:0]    wr_row;
    entry_t                wr_entry;
    logic [BANKS-1:0]      bank_hit;
    logic [15:0]           hit_symbol;

    assign wr_bank  = req.entry_index[BANK_SEL_W-1:0];
    assign wr_row   = req.entry_index[ENTRY_IDX_W-1:BANK_SEL_W];
    assign wr_entry = '{symbol:   req.entry_symbol[SYMBOL_BITS-1:0],
                        code:     req.entry_code,
                        code_len: req.entry_code_len};

    // one memory per bank; every bank reads the same row during a scan
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        entry_t mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (cmd.write && wr_bank == BANK_SEL_W'(b))
                mem[wr_row] <= wr_entry;
            if (cmd.scan)
            begin
                rd_entry_reg[b] <= mem[scan_addr_reg];
                rd_used_reg[b]  <= used_reg[{scan_addr_reg, BANK_SEL_W'(b)}];
            end
        end

        assign bank_hit[b] = rd_used_reg[b]
                          && (rd_entry_reg[b].code_len == win_len_reg)
                          && ((rd_entry_reg[b].code & mask_reg) == win_bits_reg);
    end

    // lowest bank wins; earlier rows were checked in earlier cycles
    always_comb
    begin
        hit_symbol = '0;
        for (int b = BANKS - 1; b >= 0; b--)
        begin
            if (bank_hit[b])
                hit_symbol = 16'(rd_entry_reg[b].symbol);
        end
    end

    assign stat.win_full = (win_len_reg == CODE_LEN_W'(MAX_CODE_LEN));
    assign stat.hit      = rd_valid_reg && (|bank_hit);
    assign stat.last     = rd_valid_reg && rd_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            win_bits_reg  <= '0;
            win_len_reg   <= '0;
            mask_reg      <= '0;
            scan_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.write)
                used_reg[req.entry_index] <= 1'b1;

            if (cmd.shift)
            begin
                win_bits_reg  <= {win_bits_reg[CODE_W-2:0], req.code_bit};
                win_len_reg   <= win_len_reg + 1'b1;
                mask_reg      <= {mask_reg[CODE_W-2:0], 1'b1};
                scan_addr_reg <= '0;
                rd_valid_reg  <= 1'b0;
                rd_last_reg   <= 1'b0;
            end
            else if (cmd.scan)
            begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
                rd_valid_reg  <= 1'b1;
                rd_last_reg   <= (scan_addr_reg == BANK_AW'(BANK_DEPTH - 1));
            end

            if (cmd.match || cmd.overflow)
            begin
                win_bits_reg <= '0;
                win_len_reg  <= '0;
                mask_reg     <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.match)
            res_reg <= '{symbol: hit_symbol, overflow_error: 1'b0};
        else if (cmd.overflow)
            res_reg <= '{symbol: 16'd0, overflow_error: 1'b1};
        if (cmd.push)
            rsp_reg <= res_reg;
    end

    assign rsp = rsp_reg;

    `PCBD_ASSERT(a_len_max, (win_len_reg <= CODE_LEN_W'(MAX_CODE_LEN)), "window too long")
    `PCBD_ASSERT(a_mask_len, (mask_reg == ~({CODE_W{1'b1}} << win_len_reg)), "mask out of step")
    `PCBD_ASSERT_NEVER(a_win_high, ((win_bits_reg & ~mask_reg) != '0), "bits above window")

endmodule

`default_nettype wire

// ----- hdl/prefix_code_bit_decoder.sv -----
// Load item: accepted, no result; ready again the next cycle.
// Bit item: window update, then eight table banks read one row per cycle until
// a hit or the last row; no hit gives no result. A hit queues its symbol,
// a full window an error result; each moves to the output register once free.
// Reset clears the window, all table valid flags and the output register valid.
`default_nettype none

module prefix_code_bit_decoder
    import pcbd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    pcbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req.req_type),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pcbd_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
